>>> rtl/scfd_pkg.sv
// Shared types and constants for the servo command frame decoder.
package scfd_pkg;

    localparam int FRAME_CHARS  = 15;
    localparam int GROUP_CHARS  = 5;
    localparam int FRAME_GROUPS = 3;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] CHAR_DIGIT_ZERO = 8'h30;
    localparam logic [7:0] CHAR_SERVO_LO   = 8'h31;
    localparam logic [7:0] CHAR_SERVO_HI   = 8'h33;
    localparam logic [7:0] CHAR_LED_ON     = 8'h31;

    // floor(x / 45) == (x * RECIP_45) >> RECIP_SHIFT, exact for x < 2**26
    localparam logic [26:0] RECIP_45    = 27'd95443718;
    localparam int          RECIP_SHIFT = 32;

    localparam logic [1:0] CFG_PULSE_OFFSET = 2'd0;
    localparam logic [1:0] CFG_PULSE_SPAN   = 2'd1;
    localparam logic [1:0] CFG_CLAMP_LOW    = 2'd2;
    localparam logic [1:0] CFG_CLAMP_HIGH   = 2'd3;

    localparam logic [15:0] RST_PULSE_OFFSET = 16'd150;
    localparam logic [11:0] RST_PULSE_SPAN   = 12'd490;
    localparam logic [15:0] RST_CLAMP_LOW    = 16'd150;
    localparam logic [15:0] RST_CLAMP_HIGH   = 16'd640;

    typedef struct packed {
        logic [15:0] angle;
        logic        num_ok;
        logic [1:0]  led_idx;
        logic        led_on;
    } t_group;

    typedef struct packed {
        t_group [FRAME_GROUPS-1:0] grp;
    } t_frame;

    typedef struct packed {
        logic [15:0] pulse_offset;
        logic [11:0] pulse_span;
        logic [15:0] clamp_low;
        logic [15:0] clamp_high;
    } t_cfg;

endpackage

>>> rtl/servo_command_frame_decoder.sv
// Top level: config registers, front end, request queue and back end.
// Accepts one character per cycle while the queue is not full; a frame of fifteen
// characters gives one result, loaded into the output register once the frame has
// passed the queue and its three groups have drained through the two-multiplier pipe.
// The back end works on one frame at a time and pops the next only when idle.
// Synchronous active-low reset clears position, LEDs, queue, pipe and config to defaults.
module servo_command_frame_decoder #(
    parameter int QUEUE_DEPTH = scfd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [15:0] o_servo_a_compare,
    output logic [15:0] o_servo_b_compare,
    output logic [15:0] o_servo_c_compare,
    output logic [2:0]  o_led_mask,
    output logic [2:0]  o_bad_group_mask
);

    scfd_pkg::t_cfg   r_cfg;
    scfd_pkg::t_frame w_push_data;
    scfd_pkg::t_frame w_pop_data;
    logic             w_push;
    logic             w_pop;
    logic             w_q_full;
    logic             w_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_offset <= scfd_pkg::RST_PULSE_OFFSET;
            r_cfg.pulse_span   <= scfd_pkg::RST_PULSE_SPAN;
            r_cfg.clamp_low    <= scfd_pkg::RST_CLAMP_LOW;
            r_cfg.clamp_high   <= scfd_pkg::RST_CLAMP_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scfd_pkg::CFG_PULSE_OFFSET: r_cfg.pulse_offset <= i_cfg_data;
                scfd_pkg::CFG_PULSE_SPAN:   r_cfg.pulse_span   <= i_cfg_data[11:0];
                scfd_pkg::CFG_CLAMP_LOW:    r_cfg.clamp_low    <= i_cfg_data;
                scfd_pkg::CFG_CLAMP_HIGH:   r_cfg.clamp_high   <= i_cfg_data;
            endcase
        end
    end

    scfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_rx_ready),
        .i_q_full   (w_q_full),
        .o_q_push   (w_push),
        .o_q_data   (w_push_data)
    );

    scfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_data)
    );

    scfd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (w_q_valid),
        .i_q_data          (w_pop_data),
        .o_q_pop           (w_pop),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_servo_a_compare (o_servo_a_compare),
        .o_servo_b_compare (o_servo_b_compare),
        .o_servo_c_compare (o_servo_c_compare),
        .o_led_mask        (o_led_mask),
        .o_bad_group_mask  (o_bad_group_mask)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("frame request pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("frame request popped from empty queue");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_cfg.clamp_low <= r_cfg.clamp_high) |->
        (o_servo_a_compare >= r_cfg.clamp_low && o_servo_a_compare <= r_cfg.clamp_high &&
         o_servo_c_compare >= r_cfg.clamp_low && o_servo_c_compare <= r_cfg.clamp_high))
        else $error("compare value outside clamp limits");

endmodule

>>> rtl/scfd_front.sv
// Front end: collects frame characters and classifies each group of a complete frame.
module scfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    input  logic [7:0]          i_rx_byte,
    output logic                o_rx_ready,
    input  logic                i_q_full,
    output logic                o_q_push,
    output scfd_pkg::t_frame    o_q_data
);

    localparam int STORE_CHARS = scfd_pkg::FRAME_CHARS - 1;

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [7:0] r_store [STORE_CHARS];
    logic       w_accept;
    logic       w_last;
    logic [7:0] w_chars [scfd_pkg::FRAME_CHARS];

    function automatic logic [15:0] digit_val(input logic [7:0] c);
        digit_val = {8'h00, c} - {8'h00, scfd_pkg::CHAR_DIGIT_ZERO};
    endfunction

    assign o_rx_ready = !i_q_full;
    assign w_accept   = i_rx_valid && o_rx_ready;
    assign w_last     = (r_pos == 4'(STORE_CHARS));
    assign o_q_push   = w_accept && (i_rx_byte != 8'h00) && w_last;

    always_comb begin
        if (!w_accept) begin
            n_pos = r_pos;
        end else if (i_rx_byte == 8'h00 || w_last) begin
            n_pos = 4'd0;
        end else begin
            n_pos = r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_rx_byte != 8'h00 && !w_last) begin
            r_store[r_pos] <= i_rx_byte;
        end
    end

    // last character of the frame comes straight from the input
    always_comb begin
        for (int k = 0; k < STORE_CHARS; k++) begin
            w_chars[k] = r_store[k];
        end
        w_chars[STORE_CHARS] = i_rx_byte;
    end

    always_comb begin
        logic [7:0]  num;
        logic [15:0] d0;
        logic [15:0] d1;
        logic [15:0] d2;
        for (int g = 0; g < scfd_pkg::FRAME_GROUPS; g++) begin
            num = w_chars[g*scfd_pkg::GROUP_CHARS];
            d0  = digit_val(w_chars[g*scfd_pkg::GROUP_CHARS + 2]);
            d1  = digit_val(w_chars[g*scfd_pkg::GROUP_CHARS + 3]);
            d2  = digit_val(w_chars[g*scfd_pkg::GROUP_CHARS + 4]);
            o_q_data.grp[g].angle   = d0 * 16'd100 + d1 * 16'd10 + d2;
            o_q_data.grp[g].num_ok  = (num >= scfd_pkg::CHAR_SERVO_LO) &&
                                      (num <= scfd_pkg::CHAR_SERVO_HI);
            o_q_data.grp[g].led_idx = 2'(num - scfd_pkg::CHAR_SERVO_LO);
            o_q_data.grp[g].led_on  =
                (w_chars[g*scfd_pkg::GROUP_CHARS + 1] == scfd_pkg::CHAR_LED_ON);
        end
    end

endmodule

>>> rtl/scfd_queue.sv
// Small request queue between the front end and the back end.
module scfd_queue #(
    parameter int DEPTH = scfd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  scfd_pkg::t_frame i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output scfd_pkg::t_frame o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    scfd_pkg::t_frame r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/scfd_back.sv
// Back end: maps group angles to clamped compare values, updates LEDs, holds the result.
module scfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scfd_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  scfd_pkg::t_frame i_q_data,
    output logic             o_q_pop,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [15:0]      o_servo_a_compare,
    output logic [15:0]      o_servo_b_compare,
    output logic [15:0]      o_servo_c_compare,
    output logic [2:0]       o_led_mask,
    output logic [2:0]       o_bad_group_mask
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam int         NG      = scfd_pkg::FRAME_GROUPS;

    logic [1:0]       r_state;
    scfd_pkg::t_frame r_frame;
    logic [2:0]       r_led;
    logic [2:0]       n_led;
    logic [2:0]       r_bad;
    logic [1:0]       r_issue;
    logic             w_issue;
    logic             r_v1;
    logic [1:0]       r_g1;
    logic [27:0]      r_p1;
    logic             r_v2;
    logic [1:0]       r_g2;
    logic [20:0]      r_q2;
    logic [52:0]      w_prod;
    logic [21:0]      w_raw;
    logic [15:0]      w_clamped;
    logic [15:0]      r_cmp [NG];
    logic             w_load;
    logic             r_out_valid;
    logic [15:0]      r_out_a;
    logic [15:0]      r_out_b;
    logic [15:0]      r_out_c;
    logic [2:0]       r_out_led;
    logic [2:0]       r_out_bad;

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign w_issue = (r_state == ST_RUN) && (r_issue != 2'(NG));
    assign w_load  = (r_state == ST_DONE) && (!r_out_valid || i_res_ready);

    // later groups win when servo numbers repeat
    always_comb begin
        n_led = r_led;
        for (int g = 0; g < NG; g++) begin
            if (i_q_data.grp[g].num_ok) begin
                n_led[i_q_data.grp[g].led_idx] = i_q_data.grp[g].led_on;
            end
        end
    end

    // floor(p / 180) = floor(floor(p / 4) / 45)
    assign w_prod = {27'd0, r_p1[27:2]} * {26'd0, scfd_pkg::RECIP_45};
    assign w_raw  = {6'd0, i_cfg.pulse_offset} + {1'b0, r_q2};

    always_comb begin
        if (w_raw < {6'd0, i_cfg.clamp_low}) begin
            w_clamped = i_cfg.clamp_low;
        end else if (w_raw > {6'd0, i_cfg.clamp_high}) begin
            w_clamped = i_cfg.clamp_high;
        end else begin
            w_clamped = w_raw[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_led       <= 3'd0;
            r_issue     <= 2'd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            if (w_issue) begin
                r_issue <= r_issue + 2'd1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_led   <= n_led;
                        r_issue <= 2'd0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_v2 && r_g2 == 2'(NG - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_frame <= i_q_data;
            for (int g = 0; g < NG; g++) begin
                r_bad[g] <= !i_q_data.grp[g].num_ok;
            end
        end
        r_g1 <= r_issue;
        r_p1 <= {12'd0, r_frame.grp[r_issue].angle} * {16'd0, i_cfg.pulse_span};
        r_g2 <= r_g1;
        r_q2 <= w_prod[52:scfd_pkg::RECIP_SHIFT];
        if (r_v2) begin
            r_cmp[r_g2] <= w_clamped;
        end
        if (w_load) begin
            r_out_a   <= r_cmp[0];
            r_out_b   <= r_cmp[1];
            r_out_c   <= r_cmp[2];
            r_out_led <= r_led;
            r_out_bad <= r_bad;
        end
    end

    assign o_res_valid       = r_out_valid;
    assign o_servo_a_compare = r_out_a;
    assign o_servo_b_compare = r_out_b;
    assign o_servo_c_compare = r_out_c;
    assign o_led_mask        = r_out_led;
    assign o_bad_group_mask  = r_out_bad;

endmodule
